### sv/dfatok_pkg.sv
`default_nettype none

package dfatok_pkg;

  typedef enum logic [2:0] {
    ACT_LOAD_MAP   = 3'd0,
    ACT_LOAD_TRANS = 3'd1,
    ACT_LOAD_ACC   = 3'd2,
    ACT_SCAN       = 3'd3,
    ACT_END        = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OP_SCAN,
    OP_BADCHAR,
    OP_END,
    OP_LOAD_TRANS,
    OP_LOAD_ACC
  } op_t;

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_DECIDE,
    BK_ERR2
  } bk_state_t;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    op_t        op;
    logic [3:0] state_index;
    logic [3:0] class_index;
    logic       entry_valid;
    logic [3:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  token_type;
    logic [15:0] token_length;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### sv/dfatok_fifo.sv
`default_nettype none

module dfatok_fifo #(
  parameter int WIDTH     = 8,
  parameter int DEPTH_LOG = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = 2 ** DEPTH_LOG;

  logic [WIDTH-1:0]   entry_r [DEPTH];
  logic [DEPTH_LOG-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [DEPTH_LOG:0]   count_r, count_nxt;

  assign full    = (count_r == (DEPTH_LOG+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### sv/dfatok_front.sv
`default_nettype none

module dfatok_front #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_CLASSES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_state_index,
  input  logic [3:0]        in_class_index,
  input  logic              in_entry_valid,
  input  logic [3:0]        in_entry_value,
  output dfatok_pkg::cmd_t  cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  import dfatok_pkg::*;

  logic [4:0] cmap_mem [256];
  logic [4:0] cmap_rd_r;

  logic       accept;
  logic       map_wr;
  logic       stg_valid_r, stg_valid_nxt;
  op_t        stg_op_r, stg_op_nxt;
  logic [3:0] stg_si_r;
  logic [3:0] stg_ci_r;
  logic       stg_ev_valid_r;
  logic [3:0] stg_ev_r;

  assign in_ready  = !stg_valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = stg_valid_r;

  always_comb begin
    stg_valid_nxt = 1'b0;
    stg_op_nxt    = OP_SCAN;
    map_wr        = 1'b0;
    unique case (action_t'(in_action))
      ACT_LOAD_MAP: begin
        map_wr = 1'b1;
      end
      ACT_LOAD_TRANS: begin
        stg_op_nxt    = OP_LOAD_TRANS;
        stg_valid_nxt = (32'(in_state_index) < NUM_STATES) &&
                        (32'(in_class_index) < NUM_CLASSES);
      end
      ACT_LOAD_ACC: begin
        stg_op_nxt    = OP_LOAD_ACC;
        stg_valid_nxt = (32'(in_state_index) < NUM_STATES);
      end
      ACT_SCAN: begin
        stg_op_nxt    = OP_SCAN;
        stg_valid_nxt = 1'b1;
      end
      ACT_END: begin
        stg_op_nxt    = OP_END;
        stg_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.op          = stg_op_r;
    cmd.state_index = stg_si_r;
    cmd.class_index = stg_ci_r;
    cmd.entry_valid = stg_ev_valid_r;
    cmd.entry_value = stg_ev_r;
    if (stg_op_r == OP_SCAN) begin
      cmd.class_index = cmap_rd_r[3:0];
      if (!cmap_rd_r[4] || (32'(cmap_rd_r[3:0]) >= NUM_CLASSES)) begin
        cmd.op = OP_BADCHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= accept && stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_op_r       <= stg_op_nxt;
      stg_si_r       <= in_state_index;
      stg_ci_r       <= in_class_index;
      stg_ev_valid_r <= in_entry_valid;
      stg_ev_r       <= in_entry_value;
      cmap_rd_r      <= cmap_mem[in_char_code];
      if (map_wr) begin
        cmap_mem[in_char_code] <= {in_entry_valid, in_entry_value};
      end
    end
  end

endmodule

`default_nettype wire

### sv/dfatok_back.sv
`default_nettype none

module dfatok_back #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_CLASSES = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dfatok_pkg::cmd_t  cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output dfatok_pkg::res_t  res_data,
  output logic              res_push,
  input  logic              res_full
);

  import dfatok_pkg::*;

  localparam int SW = $clog2(NUM_STATES);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = '1;

  logic [4:0]         trans_mem  [2 ** (SW + CW)];
  logic [4:0]         trans0_mem [2 ** CW];
  logic [3:0]         type_mem   [2 ** SW];
  logic [(2**SW)-1:0] acc_valid_r;
  logic [4:0]         trans_rd_r;
  logic [4:0]         trans0_rd_r;
  logic [3:0]         type_rd_r;

  bk_state_t     state_r, state_nxt;
  logic [SW-1:0] cur_state_r, cur_state_nxt;
  logic [LB-1:0] pend_r, pend_nxt;
  op_t           cur_op_r;

  logic          trans_wr;
  logic          acc_wr;
  logic          trans_rd_en;
  logic          type_rd_en;
  logic          res_want;
  logic          go;

  logic          ns_ok, ns0_ok, acc_prev, acc_ns, emit_tok, final_ok;
  logic [SW-1:0] ns, ns0, final_ns, cmd_si;
  logic [CW-1:0] cmd_ci;
  logic [LB-1:0] base_len, sat_len;

  res_t          tok_res, err_res;

  assign cmd_si = SW'(cmd.state_index);
  assign cmd_ci = CW'(cmd.class_index);

  assign ns_ok    = trans_rd_r[4] && (32'(trans_rd_r[3:0]) < NUM_STATES);
  assign ns0_ok   = trans0_rd_r[4] && (32'(trans0_rd_r[3:0]) < NUM_STATES);
  assign ns       = SW'(trans_rd_r[3:0]);
  assign ns0      = SW'(trans0_rd_r[3:0]);
  assign acc_prev = acc_valid_r[cur_state_r];
  assign acc_ns   = ns_ok && acc_valid_r[ns];
  assign emit_tok = (pend_r != '0) && acc_prev && !acc_ns;
  assign final_ok = emit_tok ? ns0_ok : ns_ok;
  assign final_ns = emit_tok ? ns0 : ns;
  assign base_len = emit_tok ? '0 : pend_r;
  assign sat_len  = (base_len == LEN_MAX) ? base_len : base_len + 1'b1;

  always_comb begin
    tok_res.kind         = KIND_TOKEN;
    tok_res.token_type   = type_rd_r;
    tok_res.token_length = 16'(pend_r);
    tok_res.last         = 1'b1;
    err_res.kind         = KIND_ERROR;
    err_res.token_type   = '0;
    err_res.token_length = '0;
    err_res.last         = 1'b1;
  end

  always_comb begin
    res_want = 1'b0;
    res_data = err_res;
    unique case (state_r)
      BK_DECIDE: begin
        unique case (cur_op_r)
          OP_SCAN: begin
            if (emit_tok) begin
              res_want      = 1'b1;
              res_data      = tok_res;
              res_data.last = final_ok;
            end else if (!final_ok) begin
              res_want = 1'b1;
            end
          end
          OP_BADCHAR: begin
            res_want = 1'b1;
          end
          OP_END: begin
            res_want = (pend_r != '0);
            if (acc_prev) begin
              res_data = tok_res;
            end
          end
          default: begin
          end
        endcase
      end
      BK_ERR2: begin
        res_want = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign go       = !res_want || !res_full;
  assign res_push = res_want && !res_full;

  always_comb begin
    state_nxt     = state_r;
    cur_state_nxt = cur_state_r;
    pend_nxt      = pend_r;
    cmd_pop       = 1'b0;
    trans_wr      = 1'b0;
    acc_wr        = 1'b0;
    trans_rd_en   = 1'b0;
    type_rd_en    = 1'b0;
    unique case (state_r)
      BK_FETCH: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op) inside
            OP_LOAD_TRANS: trans_wr = 1'b1;
            OP_LOAD_ACC:   acc_wr   = 1'b1;
            OP_SCAN, OP_BADCHAR, OP_END: begin
              trans_rd_en = (cmd.op == OP_SCAN);
              state_nxt   = BK_DECIDE;
            end
            default: begin
            end
          endcase
        end
      end
      BK_DECIDE: begin
        if (go) begin
          state_nxt     = BK_FETCH;
          cur_state_nxt = '0;
          pend_nxt      = '0;
          if (cur_op_r == OP_SCAN) begin
            if (final_ok) begin
              cur_state_nxt = final_ns;
              pend_nxt      = sat_len;
              type_rd_en    = 1'b1;
            end else if (emit_tok) begin
              state_nxt = BK_ERR2;
            end
          end
        end
      end
      BK_ERR2: begin
        if (go) begin
          state_nxt = BK_FETCH;
        end
      end
      default: begin
        state_nxt = BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      cur_state_r <= '0;
      pend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_state_r <= cur_state_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_op_r <= cmd.op;
    end
    if (trans_wr) begin
      trans_mem[{cmd_si, cmd_ci}] <= {cmd.entry_valid, cmd.entry_value};
      if (cmd.state_index == '0) begin
        trans0_mem[cmd_ci] <= {cmd.entry_valid, cmd.entry_value};
      end
    end
    if (trans_rd_en) begin
      trans_rd_r  <= trans_mem[{cur_state_r, cmd_ci}];
      trans0_rd_r <= trans0_mem[cmd_ci];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_wr) begin
      acc_valid_r[cmd_si] <= cmd.entry_valid;
      type_mem[cmd_si]    <= cmd.entry_value;
    end
    if (acc_wr && (cmd_si == cur_state_r)) begin
      type_rd_r <= cmd.entry_value;
    end else if (type_rd_en) begin
      type_rd_r <= type_mem[final_ns];
    end
  end

  a_err2_after_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ERR2) |-> (cur_state_r == '0 && pend_r == '0))
    else $error("second error result without a restart");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_token_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.kind == KIND_TOKEN) |-> (pend_r != '0))
    else $error("token emitted with nothing pending");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DECIDE && cur_op_r == OP_END && go) |=>
      (pend_r == '0 && cur_state_r == '0 && state_r == BK_FETCH))
    else $error("end of text did not restart the automaton");

endmodule

`default_nettype wire

### sv/table_driven_dfa_tokenizer_top.sv
// Streaming DFA tokenizer with longest-match token emission.
// Input channel (in_valid/in_ready) carries one transaction per item: class
// map loads, transition loads, accept loads, scanned characters and end of
// text. Result channel (out_valid/out_ready) carries tokens (kind, type,
// length) and lexical errors; last marks the final result of one input.
// Class map loads complete in the front stage and run at one per cycle
// while the front stage is not holding a command that the queue has not
// taken. Transition and accept loads pass through the command queue and
// are written in the back-end fetch state. A scanned character or end of
// text is fetched by the back end, with the transition table read for a
// character, and then decided; the decision ends before the next fetch, as
// the read depends on the state left by the previous character. A token
// followed by an error passes through an extra state that emits the error.
// A four-entry result queue decouples the receiver: when out_ready stays
// low, the back end stops only once that queue is full, and the command
// queue then fills before in_ready drops. Reset clears the automaton to
// state 0 with nothing pending and empties both queues; the tables are not
// cleared and must be loaded before scanning.
`default_nettype none

module table_driven_dfa_tokenizer_top #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_CLASSES = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_state_index,
  input  logic [3:0]  in_class_index,
  input  logic        in_entry_valid,
  input  logic [3:0]  in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [3:0]  out_token_type,
  output logic [15:0] out_token_length,
  output logic        out_last
);

  import dfatok_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_valid;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;

  res_t back_res;
  res_t out_res;
  logic res_push;
  logic res_full;
  logic res_empty;
  logic res_pop;

  assign q_push    = front_valid && !q_full;
  assign out_valid = !res_empty;
  assign res_pop   = out_valid && out_ready;

  assign out_kind         = out_res.kind;
  assign out_token_type   = out_res.token_type;
  assign out_token_length = out_res.token_length;
  assign out_last         = out_res.last;

  dfatok_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_state_index (in_state_index),
    .in_class_index (in_class_index),
    .in_entry_valid (in_entry_valid),
    .in_entry_value (in_entry_value),
    .cmd            (front_cmd),
    .cmd_valid      (front_valid),
    .cmd_ready      (!q_full)
  );

  dfatok_fifo #(
    .WIDTH     ($bits(cmd_t)),
    .DEPTH_LOG (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  dfatok_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_CLASSES (NUM_CLASSES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .res_data  (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  dfatok_fifo #(
    .WIDTH     ($bits(res_t)),
    .DEPTH_LOG (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (res_pop),
    .rd_data (out_res),
    .empty   (res_empty)
  );

endmodule

`default_nettype wire
